@@ rtl/mdsd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mdsd_pkg: shared constants for the magnetic door state detector
// Field widths, configuration register indexes, reset values and phase codes.
// ----------------------------------------------------------------------------
package mdsd_pkg;

   localparam int AXIS_W   = 17;
   localparam int SQ_W     = 2 * AXIS_W;      // squared axis sum width
   localparam int MAG_W    = 17;
   localparam int DELTA_W  = 16;
   localparam int NEED_W   = 4;
   localparam int ODELTA_W = 17;
   localparam int PHASE_W  = 2;

   localparam int REQ_DATA_W = 56;            // 3 x 17 bits, padded to bytes
   localparam int RSP_DATA_W = 48;            // 42 bits, padded to bytes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   typedef logic signed [AXIS_W-1:0] axis_type;
   typedef logic [MAG_W-1:0]         mag_type;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_STABLE_DELTA  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STABLE_NEEDED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OPEN_DELTA    = 2'd2;

   localparam logic [DELTA_W-1:0]  RST_STABLE_DELTA  = 16'd10;
   localparam logic [NEED_W-1:0]   RST_STABLE_NEEDED = 4'd5;
   localparam logic [ODELTA_W-1:0] RST_OPEN_DELTA    = 17'd250;

   // detector phase
   localparam logic [PHASE_W-1:0] PH_WAIT = 2'd0;
   localparam logic [PHASE_W-1:0] PH_CAL  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_MON  = 2'd2;

endpackage
`default_nettype wire

@@ rtl/magnetic_door_state_detector.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// magnetic_door_state_detector: door open/close detection from a magnetometer
// One sample per req transfer, one result per sample on the rsp side.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one three-axis sample (x, y, z in tdata). The block takes a
//   sample only when idle; req_tready drops for the whole computation.
//   rsp_* returns one result per sample: door state, change flag, phase,
//   stable samples left, sample magnitude and latched baseline magnitude.
//   csr_* writes the three configuration registers; csr_ready is always high.
//   Write them only while no sample is in flight.
// Sequence:
//   Magnitudes come from one 17x17 squarer and a radix-4 root iteration. A
//   sample is registered on its transfer, then passes through the square,
//   root and done states; the sample that ends calibration also computes the
//   baseline magnitude on the same unit in a second square and root pass. A
//   new sample is taken the cycle after the result is loaded into the output
//   register, so no sample is taken until the previous one is through.
// Reset: synchronous, active high; phase returns to awaiting first sample,
//   door closed, registers to their defaults, no result pending.
// Stall: a result waits in the output register while rsp_tready is low; the
//   next sample is still taken and computed, then holds until the slot frees.
// ----------------------------------------------------------------------------
module magnetic_door_state_detector (
   input  wire                                clock,
   input  wire                                reset,
   // x [16:0], y [33:17], z [50:34], zero pad above
   input  wire [mdsd_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // door_open [0], state_changed [1], phase_now [3:2], stable_left [7:4],
   // field_magnitude [24:8], baseline_magnitude [41:25], zero pad above
   output logic [mdsd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [mdsd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [mdsd_pkg::CSR_DATA_W-1:0]    csr_data
);
   import mdsd_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SQR  = 2'd1;
   localparam logic [1:0] S_ROOT = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   localparam int ROOT_STEPS = SQ_W / 2;
   localparam int REM_W      = MAG_W + 1;

   // control
   logic [1:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic       pass_ff, pass_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [DELTA_W-1:0]  stable_delta_ff;
   logic [NEED_W-1:0]   stable_needed_ff;
   logic [ODELTA_W-1:0] open_delta_ff;

   // detector state
   logic [PHASE_W-1:0] phase_ff, phase_in;
   axis_type           base_x_ff, base_y_ff, base_z_ff;
   logic [NEED_W-1:0]  count_ff, count_in;
   mag_type            base_mag_ff;
   logic               open_ff, open_in;

   // datapath
   axis_type                smp_x_ff, smp_y_ff, smp_z_ff;
   logic [SQ_W-1:0]         prod_ff;
   logic [SQ_W-1:0]         rad_ff;
   logic [REM_W-1:0]        rem_ff;
   mag_type                 root_ff;
   mag_type                 mag_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;

   // -------------------------------------------------------------------------
   // shared squarer and root step
   axis_type                op_c;
   logic signed [SQ_W-1:0]  sq_c;
   logic [REM_W+1:0]        rem_sh_c, trial_c;
   logic                    root_ge_c;
   logic [REM_W-1:0]        rem_next_c;
   mag_type                 root_next_c;

   always_comb begin
      op_c = '0;
      case (step_ff[1:0])
         2'd0:    op_c = pass_ff ? base_x_ff : smp_x_ff;
         2'd1:    op_c = pass_ff ? base_y_ff : smp_y_ff;
         2'd2:    op_c = pass_ff ? base_z_ff : smp_z_ff;
         default: op_c = '0;
      endcase
   end

   assign sq_c        = SQ_W'(op_c) * SQ_W'(op_c);
   assign rem_sh_c    = {rem_ff, rad_ff[SQ_W-1 -: 2]};
   assign trial_c     = {1'b0, root_ff, 2'b01};
   assign root_ge_c   = rem_sh_c >= trial_c;
   assign rem_next_c  = root_ge_c ? REM_W'(rem_sh_c - trial_c) : REM_W'(rem_sh_c);
   assign root_next_c = {root_ff[MAG_W-2:0], root_ge_c};

   // -------------------------------------------------------------------------
   // calibration stability check
   function automatic logic near_axis(axis_type b, axis_type s, logic [DELTA_W-1:0] d);
      logic signed [AXIS_W:0] diff;
      logic [AXIS_W:0]        mag;
      diff = {b[AXIS_W-1], b} - {s[AXIS_W-1], s};
      mag  = diff[AXIS_W] ? (AXIS_W+1)'(-diff) : diff;
      return mag < {2'b00, d};
   endfunction

   logic              stable_c;
   logic [NEED_W-1:0] count_inc_c;
   logic              complete_c;

   assign stable_c    = near_axis(base_x_ff, smp_x_ff, stable_delta_ff)
                      && near_axis(base_y_ff, smp_y_ff, stable_delta_ff)
                      && near_axis(base_z_ff, smp_z_ff, stable_delta_ff);
   assign count_inc_c = count_ff + 1'b1;
   assign complete_c  = (phase_ff == PH_CAL) && stable_c
                      && (count_inc_c >= stable_needed_ff || count_inc_c == '0);

   // -------------------------------------------------------------------------
   // end of item: door decision and state update
   logic signed [MAG_W+1:0] thr_c, mag_s_c;
   logic                    changed_c;
   logic                    load_base_c;
   logic [NEED_W-1:0]       left_c;
   logic                    out_free_c;

   assign thr_c      = $signed({2'b00, base_mag_ff}) - $signed({2'b00, open_delta_ff});
   assign mag_s_c    = $signed({2'b00, mag_ff});
   assign out_free_c = !rsp_valid_ff || rsp_tready;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      open_in     = open_ff;
      changed_c   = 1'b0;
      load_base_c = 1'b0;
      case (phase_ff)
         PH_MON: begin
            if (open_ff) begin
               if (mag_s_c >= thr_c) begin
                  open_in   = 1'b0;
                  changed_c = 1'b1;
               end
            end else if (mag_s_c <= thr_c) begin
               open_in   = 1'b1;
               changed_c = 1'b1;
            end
         end
         PH_CAL: begin
            if (stable_c) begin
               count_in = count_inc_c;
               if (complete_c) phase_in = PH_MON;
            end else begin
               count_in    = '0;
               load_base_c = 1'b1;
            end
         end
         default: begin
            load_base_c = 1'b1;
            count_in    = '0;
            phase_in    = PH_CAL;
         end
      endcase
      left_c = '0;
      if (phase_in == PH_CAL && stable_needed_ff > count_in)
         left_c = stable_needed_ff - count_in;
   end

   // -------------------------------------------------------------------------
   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      pass_in      = pass_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_SQR;
               step_in  = '0;
               pass_in  = 1'b0;
            end
         end
         S_SQR: begin
            step_in = step_ff + 1'b1;
            if (step_ff[1:0] == 2'd3) begin
               state_in = S_ROOT;
               step_in  = '0;
            end
         end
         S_ROOT: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 5'(ROOT_STEPS - 1)) begin
               step_in = '0;
               if (!pass_ff && complete_c) begin
                  state_in = S_SQR;
                  pass_in  = 1'b1;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (out_free_c) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         step_ff          <= '0;
         pass_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         stable_delta_ff  <= RST_STABLE_DELTA;
         stable_needed_ff <= RST_STABLE_NEEDED;
         open_delta_ff    <= RST_OPEN_DELTA;
         phase_ff         <= PH_WAIT;
         base_x_ff        <= '0;
         base_y_ff        <= '0;
         base_z_ff        <= '0;
         count_ff         <= '0;
         base_mag_ff      <= '0;
         open_ff          <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;

         if (csr_valid) begin
            case (csr_index)
               REG_STABLE_DELTA:  stable_delta_ff  <= csr_data[DELTA_W-1:0];
               REG_STABLE_NEEDED: stable_needed_ff <= csr_data[NEED_W-1:0];
               REG_OPEN_DELTA:    open_delta_ff    <= csr_data[ODELTA_W-1:0];
               default: ;
            endcase
         end

         if (state_ff == S_ROOT && step_ff == 5'(ROOT_STEPS - 1) && pass_ff)
            base_mag_ff <= root_next_c;

         if (state_ff == S_DONE && out_free_c) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            open_ff  <= open_in;
            if (load_base_c) begin
               base_x_ff <= smp_x_ff;
               base_y_ff <= smp_y_ff;
               base_z_ff <= smp_z_ff;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         smp_x_ff <= req_tdata[AXIS_W-1:0];
         smp_y_ff <= req_tdata[2*AXIS_W-1:AXIS_W];
         smp_z_ff <= req_tdata[3*AXIS_W-1:2*AXIS_W];
      end

      if (state_ff == S_SQR) begin
         prod_ff <= $unsigned(sq_c);
         if (step_ff[1:0] == 2'd0) rad_ff <= '0;
         else                      rad_ff <= rad_ff + prod_ff;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (state_ff == S_ROOT) begin
         rad_ff  <= {rad_ff[SQ_W-3:0], 2'b00};
         rem_ff  <= rem_next_c;
         root_ff <= root_next_c;
         if (step_ff == 5'(ROOT_STEPS - 1) && !pass_ff) mag_ff <= root_next_c;
      end

      if (state_ff == S_DONE && out_free_c) begin
         rsp_data_ff <= {6'd0, base_mag_ff, mag_ff, left_c, phase_in, changed_c,
                         (phase_in == PH_MON) ? open_in : 1'b0};
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule
`default_nettype wire

@@ rtl/mdsd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mdsd_checker: port-level checks for the magnetic door state detector
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
module mdsd_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_tvalid,
   input wire                               req_tready,
   input wire [mdsd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire                               rsp_tvalid,
   input wire                               rsp_tready
);
   import mdsd_pkg::*;

   logic [PHASE_W-1:0] rsp_phase;
   logic [NEED_W-1:0]  rsp_left;

   assign rsp_phase = rsp_tdata[3:2];
   assign rsp_left  = rsp_tdata[7:4];

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one sample at a time: input closes right after a transfer
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sample taken while busy");

   // door flags only in monitoring
   a_door_mon: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_phase != PH_MON |-> rsp_tdata[1:0] == 2'b00)
      else $error("door flags outside monitoring");

   // no stable samples left once monitoring
   a_left_mon: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_phase == PH_MON |-> rsp_left == '0)
      else $error("stable_left nonzero in monitoring");

endmodule

bind magnetic_door_state_detector mdsd_checker u_mdsd_checker (.*);
`default_nettype wire
